// ----- sv/scmc_pkg.sv -----
// Shared types and constants for the skin colour mask and centroid block.
// No dependencies; every other file refers to this package by scoped name.
package scmc_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int TALLY_W = 25;
  localparam int SUM_W   = 37;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COORD_W-1:0] CENT_MAX  = '1;
  localparam logic [PIX_W-1:0]   MASK_SKIN = 8'd255;
  localparam logic [PIX_W-1:0]   MASK_NONE = 8'd0;

  typedef enum logic [1:0] {
    REG_TARGET_RED   = 2'd0,
    REG_TARGET_GREEN = 2'd1,
    REG_TARGET_BLUE  = 2'd2,
    REG_TOLERANCE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] tolerance;
  } cfg_t;

  // classified pixel passed from front to back
  typedef struct packed {
    logic               skin;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } cls_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIVIDE,
    ST_FINISH
  } back_state_t;

endpackage

// ----- sv/scmc_if.sv -----
// Pixel and result channel interfaces (valid/ready handshake).
// Depends on scmc_pkg for field widths.
interface scmc_pixel_if;
  logic                            valid;
  logic                            ready;
  logic [scmc_pkg::PIX_W-1:0]      luma;
  logic [scmc_pkg::PIX_W-1:0]      chroma_blue;
  logic [scmc_pkg::PIX_W-1:0]      chroma_red;
  logic [scmc_pkg::COORD_W-1:0]    column;
  logic [scmc_pkg::COORD_W-1:0]    row;
  logic                            frame_end;

  modport source (output valid, luma, chroma_blue, chroma_red, column, row, frame_end,
                  input ready);
  modport sink   (input valid, luma, chroma_blue, chroma_red, column, row, frame_end,
                  output ready);
endinterface

interface scmc_result_if;
  logic                            valid;
  logic                            ready;
  logic [scmc_pkg::PIX_W-1:0]      mask_value;
  logic                            summary_valid;
  logic [scmc_pkg::TALLY_W-1:0]    matched_count;
  logic [scmc_pkg::COORD_W-1:0]    centroid_column;
  logic [scmc_pkg::COORD_W-1:0]    centroid_row;

  modport source (output valid, mask_value, summary_valid, matched_count,
                  centroid_column, centroid_row, input ready);
  modport sink   (input valid, mask_value, summary_valid, matched_count,
                  centroid_column, centroid_row, output ready);
endinterface

// ----- sv/scmc_front.sv -----
// Front end: two-stage pipeline doing BT.601 YUV to RGB, clamp and colour match.
// Depends on scmc_pkg and scmc_pixel_if; pushes classified items to the queue.
module scmc_front #(
  parameter int FRAME_WIDTH  = 3072,
  parameter int FRAME_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  scmc_pkg::cfg_t       cfg,
  scmc_pixel_if.sink           pix,
  output logic                 push_valid,
  input  logic                 push_ready,
  output scmc_pkg::cls_t       push_item
);

  localparam int PW = 19;
  localparam int QW = PW - 8;
  localparam int CW = scmc_pkg::COORD_W + 1;

  function automatic logic [7:0] chan(input logic signed [PW-1:0] v);
    logic signed [QW-1:0] q;
    q = QW'(v >>> 8);
    if (q < 0) return 8'd0;
    else if (q > QW'(255)) return 8'd255;
    else return q[7:0];
  endfunction

  function automatic logic near(input logic [7:0] c, input logic [7:0] t,
                                input logic [7:0] tol);
    logic [7:0] d;
    d = (c >= t) ? c - t : t - c;
    return d <= tol;
  endfunction

  logic signed [9:0] c_v, d_v, e_v;
  logic              in_frame;

  // stage 1: products
  logic                 s1_valid;
  logic signed [PW-1:0] p_c298, p_e409, p_d100, p_e208, p_d516;
  logic                 s1_in_frame, s1_frame_end;
  logic [scmc_pkg::COORD_W-1:0] s1_column, s1_row;

  // stage 2: classification
  logic           s2_valid;
  scmc_pkg::cls_t s2_item;

  logic signed [PW-1:0] r_sum, g_sum, b_sum;
  logic [7:0]           r_ch, g_ch, b_ch;
  logic                 s1_adv, s2_adv;

  assign s2_adv    = !s2_valid || push_ready;
  assign s1_adv    = !s1_valid || s2_adv;
  assign pix.ready = s1_adv;

  always_comb begin
    c_v      = $signed({2'b00, pix.luma}) - 10'sd16;
    d_v      = $signed({2'b00, pix.chroma_blue}) - 10'sd128;
    e_v      = $signed({2'b00, pix.chroma_red}) - 10'sd128;
    in_frame = ({1'b0, pix.column} < CW'(FRAME_WIDTH)) &&
               ({1'b0, pix.row} < CW'(FRAME_HEIGHT));
  end

  always_comb begin
    r_sum = p_c298 + p_e409 + PW'(128);
    g_sum = p_c298 - p_d100 - p_e208 + PW'(128);
    b_sum = p_c298 + p_d516 + PW'(128);
    r_ch  = chan(r_sum);
    g_ch  = chan(g_sum);
    b_ch  = chan(b_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= pix.valid;
      if (s2_adv) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      p_c298       <= PW'(c_v) * PW'(298);
      p_e409       <= PW'(e_v) * PW'(409);
      p_d100       <= PW'(d_v) * PW'(100);
      p_e208       <= PW'(e_v) * PW'(208);
      p_d516       <= PW'(d_v) * PW'(516);
      s1_in_frame  <= in_frame;
      s1_column    <= pix.column;
      s1_row       <= pix.row;
      s1_frame_end <= pix.frame_end;
    end
    if (s2_adv) begin
      s2_item.skin      <= s1_in_frame && near(r_ch, cfg.red, cfg.tolerance) &&
                           near(g_ch, cfg.green, cfg.tolerance) &&
                           near(b_ch, cfg.blue, cfg.tolerance);
      s2_item.column    <= s1_column;
      s2_item.row       <= s1_row;
      s2_item.frame_end <= s1_frame_end;
    end
  end

  assign push_valid = s2_valid;
  assign push_item  = s2_item;

endmodule

// ----- sv/scmc_queue.sv -----
// Short FIFO of classified items between front and back.
// Depends on scmc_pkg for the item type and depth.
module scmc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  scmc_pkg::cls_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output scmc_pkg::cls_t pop_item
);

  localparam int CNT_W = $clog2(scmc_pkg::QUEUE_DEPTH + 1);

  scmc_pkg::cls_t                entries [scmc_pkg::QUEUE_DEPTH];
  logic [scmc_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]              count;
  logic                          do_push, do_pop;

  assign push_ready = count != CNT_W'(scmc_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

// ----- sv/scmc_back.sv -----
// Back end: accumulates count and coordinate sums, divides at frame end, holds result.
// Depends on scmc_pkg and scmc_result_if; pops items from scmc_queue.
module scmc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  scmc_pkg::cls_t q_item,
  output logic           q_pop,
  scmc_result_if.source  res
);

  localparam int SW = scmc_pkg::SUM_W;
  localparam int TW = scmc_pkg::TALLY_W;
  localparam int KW = scmc_pkg::COORD_W;
  localparam int STEP_W = $clog2(SW);

  typedef struct packed {
    logic [TW-1:0] rem;
    logic [SW-1:0] num;
  } div_t;

  function automatic div_t div_step(input div_t cur, input logic [TW-1:0] den);
    logic [TW:0] sh;
    logic        ge;
    div_t        nx;
    sh     = {cur.rem, cur.num[SW-1]};
    ge     = sh >= {1'b0, den};
    nx.rem = ge ? TW'(sh - {1'b0, den}) : TW'(sh);
    nx.num = {cur.num[SW-2:0], ge};
    return nx;
  endfunction

  function automatic logic [KW-1:0] sat(input logic [SW-1:0] q);
    return (q[SW-1:KW] != '0) ? scmc_pkg::CENT_MAX : q[KW-1:0];
  endfunction

  scmc_pkg::back_state_t state, state_next;

  logic [TW-1:0]     tally;
  logic [SW-1:0]     column_sum, row_sum;
  logic [TW-1:0]     tally_add;
  logic [SW-1:0]     column_add, row_add;

  div_t              div_col, div_row;
  logic [TW-1:0]     divisor;
  logic [7:0]        held_mask;
  logic [STEP_W-1:0] step;

  logic              out_free, last_step, frame_close, load_plain, load_summary;

  logic              out_valid;
  logic [7:0]        out_mask;
  logic              out_summary;
  logic [TW-1:0]     out_count;
  logic [KW-1:0]     out_col, out_row;

  assign out_free    = !out_valid || res.ready;
  assign q_pop       = (state == scmc_pkg::ST_RUN) && q_valid && out_free;
  assign last_step   = step == STEP_W'(SW - 1);
  assign frame_close = q_pop && q_item.frame_end;

  always_comb begin
    tally_add  = tally + TW'(q_item.skin);
    column_add = column_sum + (q_item.skin ? SW'(q_item.column) : '0);
    row_add    = row_sum + (q_item.skin ? SW'(q_item.row) : '0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scmc_pkg::ST_RUN:    if (frame_close && tally_add != '0) state_next = scmc_pkg::ST_DIVIDE;
      scmc_pkg::ST_DIVIDE: if (last_step) state_next = scmc_pkg::ST_FINISH;
      scmc_pkg::ST_FINISH: if (out_free) state_next = scmc_pkg::ST_RUN;
      default:             state_next = scmc_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    load_plain   = 1'b0;
    load_summary = 1'b0;
    unique case (state)
      scmc_pkg::ST_RUN:    load_plain   = q_pop && !(q_item.frame_end && tally_add != '0);
      scmc_pkg::ST_FINISH: load_summary = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= scmc_pkg::ST_RUN;
      tally      <= '0;
      column_sum <= '0;
      row_sum    <= '0;
      step       <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        if (q_item.frame_end) begin
          tally      <= '0;
          column_sum <= '0;
          row_sum    <= '0;
        end else begin
          tally      <= tally_add;
          column_sum <= column_add;
          row_sum    <= row_add;
        end
      end
      if (state == scmc_pkg::ST_DIVIDE) step <= last_step ? '0 : step + 1'b1;
      if (load_plain || load_summary) out_valid <= 1'b1;
      else if (res.ready)             out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_close) begin
      divisor     <= tally_add;
      div_col     <= '{rem: '0, num: column_add};
      div_row     <= '{rem: '0, num: row_add};
      held_mask   <= q_item.skin ? scmc_pkg::MASK_SKIN : scmc_pkg::MASK_NONE;
    end else if (state == scmc_pkg::ST_DIVIDE) begin
      div_col <= div_step(div_col, divisor);
      div_row <= div_step(div_row, divisor);
    end
    if (load_plain) begin
      out_mask    <= q_item.skin ? scmc_pkg::MASK_SKIN : scmc_pkg::MASK_NONE;
      out_summary <= 1'b0;
      out_count   <= '0;
      out_col     <= '0;
      out_row     <= '0;
    end else if (load_summary) begin
      out_mask    <= held_mask;
      out_summary <= 1'b1;
      out_count   <= divisor;
      out_col     <= sat(div_col.num);
      out_row     <= sat(div_row.num);
    end
  end

  assign res.valid           = out_valid;
  assign res.mask_value      = out_mask;
  assign res.summary_valid   = out_summary;
  assign res.matched_count   = out_count;
  assign res.centroid_column = out_col;
  assign res.centroid_row    = out_row;

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    state != scmc_pkg::ST_RUN |-> !q_pop)
    else $error("item popped while divider busy");

  a_clear_on_close: assert property (@(posedge clk) disable iff (rst)
    frame_close |=> tally == '0 && column_sum == '0 && row_sum == '0)
    else $error("sums not cleared at frame end");

  a_summary_count: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.summary_valid |-> res.matched_count != '0)
    else $error("summary with zero count");

  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.summary_valid |->
      res.matched_count == '0 && res.centroid_column == '0 && res.centroid_row == '0)
    else $error("summary fields set without summary");

  a_divide_len: assert property (@(posedge clk) disable iff (rst)
    $rose(state == scmc_pkg::ST_FINISH) |-> $past(state == scmc_pkg::ST_DIVIDE))
    else $error("finish entered without divide");

endmodule

// ----- sv/skin_color_mask_centroid.sv -----
// Skin colour mask and centroid: front classifier, item queue, accumulator/divider back.
// Path registers: front stages 1 and 2, queue, output. One pixel per cycle unless res.ready
// stalls; a frame's last pixel with a nonzero count adds a 37-step restoring division
// of both coordinate sums, then result load, while six more pixels fill the front and queue.
// Synchronous active-high reset clears pipeline, queue, sums and restores target colour.
// Depends on scmc_pkg, scmc_if, scmc_front, scmc_queue, scmc_back.
module skin_color_mask_centroid #(
  parameter int FRAME_WIDTH  = 3072,
  parameter int FRAME_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [scmc_pkg::PIX_W-1:0]      cfg_data,
  scmc_pixel_if.sink                      pix,
  scmc_result_if.source                   res
);

  scmc_pkg::cfg_t cfg;
  logic           push_valid, push_ready, q_valid, q_pop;
  scmc_pkg::cls_t push_item, q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{red: 8'd143, green: 8'd103, blue: 8'd80, tolerance: 8'd29};
    end else if (cfg_we) begin
      unique case (scmc_pkg::cfg_reg_t'(cfg_index))
        scmc_pkg::REG_TARGET_RED:   cfg.red       <= cfg_data;
        scmc_pkg::REG_TARGET_GREEN: cfg.green     <= cfg_data;
        scmc_pkg::REG_TARGET_BLUE:  cfg.blue      <= cfg_data;
        scmc_pkg::REG_TOLERANCE:    cfg.tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  scmc_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pix        (pix),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  scmc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  scmc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule
